// ----- sv/spm_pkg.sv -----
// ----------------------------------------------------------------------------
// spm_pkg
// shared types, widths and helpers of the support polygon stability margin
// ----------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

  localparam int NUM_FEET   = 6;
  localparam int COORD_BITS = 16;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 3;
  localparam int MASK_W    = 6;
  localparam int FOOT_W    = $clog2(NUM_FEET);
  localparam int CNT_W     = $clog2(NUM_FEET + 1);
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int MUL_W     = DIFF_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int LEN_W     = 2 * DIFF_W;
  localparam int AC_W      = 2 * DIFF_W;
  localparam int HALF_W    = AC_W / 2;
  localparam int ACC_W     = 2 * AC_W + 2;
  localparam int QUO_W     = 2 * DIFF_W + 2;
  localparam int ROOT_W    = QUO_W / 2;
  localparam int REM_W     = LEN_W;
  localparam int SUM_W     = COORD_BITS + CNT_W;
  localparam int MARGIN_W  = 17;
  localparam int CNTU_W    = $clog2(QUO_W + 1);

  localparam logic [MARGIN_W-1:0] MARGIN_MAX = '1;

  localparam logic [OP_W-1:0] OP_FOOT   = 2'd0;
  localparam logic [OP_W-1:0] OP_MASK   = 2'd1;
  localparam logic [OP_W-1:0] OP_COM    = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]              op;
    logic [IDX_W-1:0]             foot_index;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [MASK_W-1:0]            grounded_bits;
    logic                         commit;
  } in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] centroid_x;
    logic signed [COORD_BITS-1:0] centroid_y;
    logic [MARGIN_W-1:0]          margin;
    logic [2:0]                   support_count;
    logic                         margin_valid;
  } out_t;

  typedef struct packed {
    logic             start;
    logic             div_en;
    logic             sqrt_en;
    logic [ACC_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } unit_req_t;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quo;
    logic [ROOT_W-1:0] root;
  } unit_rsp_t;

  // next grounded foot after a, wrapping; a itself if it is the only one
  function automatic logic [FOOT_W-1:0] next_set(input logic [NUM_FEET-1:0] mask,
                                                  input logic [FOOT_W-1:0] a);
    logic [FOOT_W:0]   j;
    logic [FOOT_W-1:0] r;
    logic              found;
    r = a;
    found = 1'b0;
    for (int k = 1; k <= NUM_FEET; k++) begin
      j = (FOOT_W+1)'(a) + (FOOT_W+1)'(k);
      if (j >= (FOOT_W+1)'(NUM_FEET)) j = j - (FOOT_W+1)'(NUM_FEET);
      if (!found && mask[j[FOOT_W-1:0]]) begin
        r = j[FOOT_W-1:0];
        found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/spm_if.sv -----
// ----------------------------------------------------------------------------
// spm_in_if / spm_out_if
// valid/ready channels for input and result transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface spm_in_if;
  logic         valid;
  logic         ready;
  spm_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spm_out_if;
  logic          valid;
  logic          ready;
  spm_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/spm_divsqrt.sv -----
// ----------------------------------------------------------------------------
// spm_divsqrt
// shared iterative unit: restoring divide, one bit a cycle, integer square
// root alone or after the divide, one result bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module spm_divsqrt (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spm_pkg::unit_req_t req_i,
  output spm_pkg::unit_rsp_t      rsp_o
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_DIV  = 2'd1;
  localparam logic [1:0] U_SQRT = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [spm_pkg::CNTU_W-1:0]   cnt_q, cnt_d;
  logic                         sqrt_q, sqrt_d;
  logic                         done_q, done_d;
  logic [spm_pkg::LEN_W-1:0]    den_q, den_d;
  logic [spm_pkg::REM_W-1:0]    rem_q, rem_d;
  logic [spm_pkg::QUO_W-1:0]    dvd_q, dvd_d;
  logic [spm_pkg::ROOT_W+1:0]   srem_q, srem_d;
  logic [spm_pkg::ROOT_W-1:0]   root_q, root_d;

  logic [spm_pkg::REM_W:0]      dt;
  logic [spm_pkg::ROOT_W+3:0]   st;
  logic [spm_pkg::ROOT_W+3:0]   trial;

  assign dt    = {rem_q, dvd_q[spm_pkg::QUO_W-1]};
  assign st    = {srem_q, dvd_q[spm_pkg::QUO_W-1 -: 2]};
  assign trial = (spm_pkg::ROOT_W+4)'({root_q, 2'b01});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sqrt_d  = sqrt_q;
    done_d  = 1'b0;
    den_d   = den_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    srem_d  = srem_q;
    root_d  = root_q;
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          den_d  = req_i.divisor;
          sqrt_d = req_i.sqrt_en;
          rem_d  = req_i.dividend[spm_pkg::ACC_W-1:spm_pkg::QUO_W];
          dvd_d  = req_i.dividend[spm_pkg::QUO_W-1:0];
          srem_d = '0;
          root_d = '0;
          if (req_i.div_en) begin
            state_d = U_DIV;
            cnt_d   = spm_pkg::CNTU_W'(spm_pkg::QUO_W - 1);
          end else begin
            state_d = U_SQRT;
            cnt_d   = spm_pkg::CNTU_W'(spm_pkg::ROOT_W - 1);
          end
        end
      end
      U_DIV: begin
        if (dt >= {1'b0, den_q}) begin
          rem_d = spm_pkg::REM_W'(dt - {1'b0, den_q});
          dvd_d = {dvd_q[spm_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_d = dt[spm_pkg::REM_W-1:0];
          dvd_d = {dvd_q[spm_pkg::QUO_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (sqrt_q) begin
            state_d = U_SQRT;
            cnt_d   = spm_pkg::CNTU_W'(spm_pkg::ROOT_W - 1);
          end else begin
            state_d = U_IDLE;
            done_d  = 1'b1;
          end
        end
      end
      U_SQRT: begin
        dvd_d = {dvd_q[spm_pkg::QUO_W-3:0], 2'b00};
        if (st >= trial) begin
          srem_d = (spm_pkg::ROOT_W+2)'(st - trial);
          root_d = {root_q[spm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          srem_d = st[spm_pkg::ROOT_W+1:0];
          root_d = {root_q[spm_pkg::ROOT_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = U_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      sqrt_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sqrt_q  <= sqrt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = dvd_q;
  assign rsp_o.root = root_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == U_IDLE)
    else $error("unit started while busy");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == U_DIV |-> rem_q < den_q)
    else $error("division remainder out of range");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == U_DIV || $past(state_q) == U_SQRT)
    else $error("done without work");

endmodule

`default_nettype wire

// ----- sv/support_polygon_stability_margin.sv -----
// ----------------------------------------------------------------------------
// support_polygon_stability_margin
// stores feet, grounded mask and center of mass; builds the support polygon
// and gives its centroid and the center-of-mass to edge margin
// ----------------------------------------------------------------------------
// channel  dir  payload                                   transaction
// in_i     in   op, foot_index, x, y, grounded_bits,      valid & ready
//               commit
// out_o    out  centroid_x, centroid_y, margin,            valid & ready
//               support_count, margin_valid
//
// a computing transaction scans all six feet, finds the centroid with two
// 36-step divisions and then works through each polygon edge (four products
// for the edge test, five for the squared cross product, a 36-step divide and an
// 18-step root on the shared unit); if an end is nearest, its distance is squared, no divide.
// in_i.ready is low while computing.
// a waiting result sits in the output register; in_i still takes
// transactions, and a new result waits until that register is free.
// reset clears the stored feet, mask, center of mass and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module support_polygon_stability_margin (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spm_in_if.sink    in_i,
  spm_out_if.source out_o
);

  localparam int CW = spm_pkg::COORD_BITS;
  localparam int DW = spm_pkg::DIFF_W;
  localparam int MW = spm_pkg::MUL_W;
  localparam int AW = spm_pkg::ACC_W;
  localparam int FW = spm_pkg::FOOT_W;
  localparam int NW = spm_pkg::CNT_W;
  localparam int SW = spm_pkg::SUM_W;
  localparam int HW = spm_pkg::HALF_W;
  localparam int NF = spm_pkg::NUM_FEET;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_GATHER = 5'd1;
  localparam logic [4:0] S_CXGO   = 5'd2;
  localparam logic [4:0] S_CXWAIT = 5'd3;
  localparam logic [4:0] S_CYGO   = 5'd4;
  localparam logic [4:0] S_CYWAIT = 5'd5;
  localparam logic [4:0] S_FETCHA = 5'd6;
  localparam logic [4:0] S_FETCHB = 5'd7;
  localparam logic [4:0] S_LEN1   = 5'd8;
  localparam logic [4:0] S_LEN2   = 5'd9;
  localparam logic [4:0] S_DOT1   = 5'd10;
  localparam logic [4:0] S_DOT2   = 5'd11;
  localparam logic [4:0] S_DECIDE = 5'd12;
  localparam logic [4:0] S_PT1    = 5'd13;
  localparam logic [4:0] S_PT2    = 5'd14;
  localparam logic [4:0] S_PTGO   = 5'd15;
  localparam logic [4:0] S_CR1    = 5'd16;
  localparam logic [4:0] S_CR2    = 5'd17;
  localparam logic [4:0] S_CRABS  = 5'd18;
  localparam logic [4:0] S_SQ1    = 5'd19;
  localparam logic [4:0] S_SQ2    = 5'd20;
  localparam logic [4:0] S_SQ3    = 5'd21;
  localparam logic [4:0] S_CRGO   = 5'd22;
  localparam logic [4:0] S_EWAIT  = 5'd23;
  localparam logic [4:0] S_FINISH = 5'd24;

  logic [4:0] state_q, state_d;

  logic signed [CW-1:0] foot_x_q [NF];
  logic signed [CW-1:0] foot_y_q [NF];
  logic [NF-1:0]        mask_q;
  logic signed [CW-1:0] com_x_q, com_y_q;
  logic                 have_pos_q, have_mask_q;

  logic [FW-1:0] idx_q, idx_d;
  logic [FW-1:0] first_q, first_d;
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] edge_q, edge_d;
  logic signed [SW-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic signed [CW-1:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [DW-1:0] ptx_q, ptx_d, pty_q, pty_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic [spm_pkg::LEN_W-1:0]    len2_q, len2_d;
  logic [spm_pkg::AC_W-1:0]     ac_q, ac_d;
  logic [spm_pkg::MARGIN_W-1:0] best_q, best_d;

  logic          out_valid_q;
  spm_pkg::out_t out_q;
  logic          load_out;

  spm_pkg::unit_req_t u_req;
  spm_pkg::unit_rsp_t u_rsp;

  logic          accept, foot_ok, trigger, new_pos, new_mask;
  logic [FW-1:0] rd_idx, nxt;
  logic signed [CW-1:0] rd_x, rd_y;
  logic signed [DW-1:0] dx, dy, ex, ey, fx, fy;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [spm_pkg::PROD_W-1:0] prod;
  logic signed [AW-1:0] term;
  logic [6:0]    sh;
  logic          acc_clr, acc_sub, acc_en;
  logic [SW-1:0] mag;
  logic [spm_pkg::ROOT_W-1:0] rnd;
  logic signed [SW-1:0] cur_sum;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign foot_ok    = (in_i.data.foot_index < spm_pkg::IDX_W'(NF));

  always_comb begin
    new_pos  = have_pos_q;
    new_mask = have_mask_q;
    trigger  = 1'b0;
    case (in_i.data.op)
      spm_pkg::OP_FOOT: begin
        if (foot_ok && in_i.data.commit) begin
          new_pos = 1'b1;
          trigger = 1'b1;
        end
      end
      spm_pkg::OP_MASK: begin
        new_mask = 1'b1;
        trigger  = 1'b1;
      end
      spm_pkg::OP_COM: trigger = 1'b1;
      default: trigger = 1'b0;
    endcase
    trigger = trigger && new_pos && new_mask;
  end

  // stored state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NF; i++) begin
        foot_x_q[i] <= '0;
        foot_y_q[i] <= '0;
      end
      mask_q      <= '0;
      com_x_q     <= '0;
      com_y_q     <= '0;
      have_pos_q  <= 1'b0;
      have_mask_q <= 1'b0;
    end else if (accept) begin
      have_pos_q  <= new_pos;
      have_mask_q <= new_mask;
      case (in_i.data.op)
        spm_pkg::OP_FOOT: begin
          if (foot_ok) begin
            foot_x_q[in_i.data.foot_index[FW-1:0]] <= in_i.data.x;
            foot_y_q[in_i.data.foot_index[FW-1:0]] <= in_i.data.y;
          end
        end
        spm_pkg::OP_MASK: mask_q <= in_i.data.grounded_bits[NF-1:0];
        spm_pkg::OP_COM: begin
          com_x_q <= in_i.data.x;
          com_y_q <= in_i.data.y;
        end
        default: mask_q <= mask_q;
      endcase
    end
  end

  // single read port on the foot store
  assign nxt    = spm_pkg::next_set(mask_q, idx_q);
  assign rd_idx = (state_q == S_FETCHB) ? nxt : idx_q;
  assign rd_x   = foot_x_q[rd_idx];
  assign rd_y   = foot_y_q[rd_idx];

  assign dx = DW'(bx_q) - DW'(ax_q);
  assign dy = DW'(by_q) - DW'(ay_q);
  assign ex = DW'(com_x_q) - DW'(ax_q);
  assign ey = DW'(com_y_q) - DW'(ay_q);
  assign fx = DW'(com_x_q) - DW'(bx_q);
  assign fy = DW'(com_y_q) - DW'(by_q);

  // shared multiply-accumulate
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    sh      = '0;
    acc_clr = 1'b0;
    acc_sub = 1'b0;
    acc_en  = 1'b1;
    case (state_q)
      S_LEN1:  begin mul_a = MW'(dx); mul_b = MW'(dx); acc_clr = 1'b1; end
      S_LEN2:  begin mul_a = MW'(dy); mul_b = MW'(dy); end
      S_DOT1:  begin mul_a = MW'(ex); mul_b = MW'(dx); acc_clr = 1'b1; end
      S_DOT2:  begin mul_a = MW'(ey); mul_b = MW'(dy); end
      S_PT1:   begin mul_a = MW'(ptx_q); mul_b = MW'(ptx_q); acc_clr = 1'b1; end
      S_PT2:   begin mul_a = MW'(pty_q); mul_b = MW'(pty_q); end
      S_CR1:   begin mul_a = MW'(ex); mul_b = MW'(dy); acc_clr = 1'b1; end
      S_CR2:   begin mul_a = MW'(ey); mul_b = MW'(dx); acc_sub = 1'b1; end
      S_SQ1: begin
        mul_a   = MW'({1'b0, ac_q[HW-1:0]});
        mul_b   = MW'({1'b0, ac_q[HW-1:0]});
        acc_clr = 1'b1;
      end
      S_SQ2: begin
        mul_a = MW'({1'b0, ac_q[2*HW-1:HW]});
        mul_b = MW'({1'b0, ac_q[HW-1:0]});
        sh    = 7'(HW + 1);
      end
      S_SQ3: begin
        mul_a = MW'({1'b0, ac_q[2*HW-1:HW]});
        mul_b = MW'({1'b0, ac_q[2*HW-1:HW]});
        sh    = 7'(2 * HW);
      end
      default: acc_en = 1'b0;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign term = AW'(prod) <<< sh;

  always_comb begin
    acc_d = acc_q;
    if (acc_en) begin
      if (acc_clr)      acc_d = term;
      else if (acc_sub) acc_d = acc_q - term;
      else              acc_d = acc_q + term;
    end
  end

  assign cur_sum = (state_q == S_CXGO) ? sum_x_q : sum_y_q;
  assign mag     = cur_sum[SW-1] ? SW'(-cur_sum) : SW'(cur_sum);
  assign rnd     = spm_pkg::ROOT_W'((u_rsp.root + 1'b1) >> 1);

  // sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    first_d  = first_q;
    n_d      = n_q;
    edge_d   = edge_q;
    sum_x_d  = sum_x_q;
    sum_y_d  = sum_y_q;
    ax_d     = ax_q;
    ay_d     = ay_q;
    bx_d     = bx_q;
    by_d     = by_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    ptx_d    = ptx_q;
    pty_d    = pty_q;
    len2_d   = len2_q;
    ac_d     = ac_q;
    best_d   = best_q;
    load_out = 1'b0;
    u_req    = '0;
    case (state_q)
      S_IDLE: begin
        if (accept && trigger) begin
          state_d = S_GATHER;
          idx_d   = '0;
          first_d = '0;
          n_d     = '0;
          sum_x_d = '0;
          sum_y_d = '0;
          cx_d    = '0;
          cy_d    = '0;
          best_d  = spm_pkg::MARGIN_MAX;
        end
      end
      S_GATHER: begin
        if (mask_q[idx_q]) begin
          sum_x_d = sum_x_q + SW'(rd_x);
          sum_y_d = sum_y_q + SW'(rd_y);
          n_d     = n_q + 1'b1;
          if (n_q == '0) first_d = idx_q;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == FW'(NF - 1)) state_d = S_CXGO;
      end
      S_CXGO, S_CYGO: begin
        if (n_q == '0) begin
          state_d = S_FINISH;
        end else begin
          u_req.start    = 1'b1;
          u_req.div_en   = 1'b1;
          u_req.dividend = AW'({mag, 1'b0}) + AW'(n_q);
          u_req.divisor  = spm_pkg::LEN_W'({n_q, 1'b0});
          state_d = (state_q == S_CXGO) ? S_CXWAIT : S_CYWAIT;
        end
      end
      S_CXWAIT: begin
        if (u_rsp.done) begin
          cx_d    = sum_x_q[SW-1] ? -CW'(u_rsp.quo) : CW'(u_rsp.quo);
          state_d = S_CYGO;
        end
      end
      S_CYWAIT: begin
        if (u_rsp.done) begin
          cy_d    = sum_y_q[SW-1] ? -CW'(u_rsp.quo) : CW'(u_rsp.quo);
          idx_d   = first_q;
          edge_d  = '0;
          state_d = S_FETCHA;
        end
      end
      S_FETCHA: begin
        ax_d    = rd_x;
        ay_d    = rd_y;
        state_d = S_FETCHB;
      end
      S_FETCHB: begin
        bx_d    = rd_x;
        by_d    = rd_y;
        state_d = S_LEN1;
      end
      S_LEN1: state_d = S_LEN2;
      S_LEN2: state_d = S_DOT1;
      S_DOT1: begin
        len2_d  = acc_q[spm_pkg::LEN_W-1:0];
        state_d = S_DOT2;
      end
      S_DOT2: state_d = S_DECIDE;
      S_DECIDE: begin
        if (len2_q == '0 || acc_q[AW-1] || acc_q == '0) begin
          ptx_d   = ex;
          pty_d   = ey;
          state_d = S_PT1;
        end else if (acc_q >= $signed(AW'(len2_q))) begin
          ptx_d   = fx;
          pty_d   = fy;
          state_d = S_PT1;
        end else begin
          state_d = S_CR1;
        end
      end
      S_PT1: state_d = S_PT2;
      S_PT2: state_d = S_PTGO;
      S_PTGO: begin
        u_req.start    = 1'b1;
        u_req.sqrt_en  = 1'b1;
        u_req.dividend = AW'(acc_q <<< 2);
        u_req.divisor  = spm_pkg::LEN_W'(1);
        state_d = S_EWAIT;
      end
      S_CR1: state_d = S_CR2;
      S_CR2: state_d = S_CRABS;
      S_CRABS: begin
        ac_d    = acc_q[AW-1] ? spm_pkg::AC_W'(-acc_q) : spm_pkg::AC_W'(acc_q);
        state_d = S_SQ1;
      end
      S_SQ1: state_d = S_SQ2;
      S_SQ2: state_d = S_SQ3;
      S_SQ3: state_d = S_CRGO;
      S_CRGO: begin
        u_req.start    = 1'b1;
        u_req.div_en   = 1'b1;
        u_req.sqrt_en  = 1'b1;
        u_req.dividend = AW'(acc_q <<< 2);
        u_req.divisor  = len2_q;
        state_d = S_EWAIT;
      end
      S_EWAIT: begin
        if (u_rsp.done) begin
          if (rnd < spm_pkg::ROOT_W'(best_q)) best_d = spm_pkg::MARGIN_W'(rnd);
          edge_d = edge_q + 1'b1;
          idx_d  = nxt;
          if (edge_q == NW'(n_q - 1'b1)) state_d = S_FINISH;
          else                            state_d = S_FETCHA;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      edge_q      <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      best_q      <= spm_pkg::MARGIN_MAX;
    end else begin
      state_q <= state_d;
      edge_q  <= edge_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      best_q  <= best_d;
      if (load_out)          out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    sum_x_q <= sum_x_d;
    sum_y_q <= sum_y_d;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    ptx_q   <= ptx_d;
    pty_q   <= pty_d;
    acc_q   <= acc_d;
    len2_q  <= len2_d;
    ac_q    <= ac_d;
    if (load_out) begin
      out_q.centroid_x    <= cx_q;
      out_q.centroid_y    <= cy_q;
      out_q.margin        <= best_q;
      out_q.support_count <= 3'(n_q);
      out_q.margin_valid  <= (n_q != '0);
    end
  end

  spm_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req),
    .rsp_o  (u_rsp)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_empty_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && n_q == '0) |-> best_q == spm_pkg::MARGIN_MAX)
    else $error("margin not saturated without support");

  a_edge_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EWAIT |-> edge_q < n_q)
    else $error("edge count beyond polygon");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(NF))
    else $error("support count out of range");

endmodule

`default_nettype wire

// ----- tb/support_polygon_stability_margin_test.sv -----
// ----------------------------------------------------------------------------
// support_polygon_stability_margin_test
// drives foot, mask, center-of-mass and unused-opcode writes with random idling on both
// channels and compares each result with a predicted centroid, margin, support count and margin_valid
// ----------------------------------------------------------------------------
`default_nettype none

module support_polygon_stability_margin_test;

  localparam int STALL_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  spm_in_if  in_ch();
  spm_out_if out_ch();

  support_polygon_stability_margin dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  longint feet_x[spm_pkg::NUM_FEET];
  longint feet_y[spm_pkg::NUM_FEET];
  logic [spm_pkg::NUM_FEET-1:0] mask_q;
  longint com_xq, com_yq;
  bit got_positions, got_mask;
  spm_pkg::out_t expected_results[$];
  int errors;
  bit idle_on;
  int quiet_cycles;
  int out_gap;

  function automatic longint rounded_root(longint unsigned num_hi, longint unsigned num_lo,
                                          longint unsigned den);
    logic [129:0] f;
    logic [129:0] p;
    longint unsigned lo, hi, q, t;
    f = {num_hi, num_lo} << 2;
    lo = 0;
    hi = 64'd1 << 21;
    while (hi - lo > 1) begin
      q = lo + ((hi - lo) >> 1);
      t = 2 * q - 1;
      p = 130'(t * t) * 130'(den);
      if (p <= f) lo = q;
      else hi = q;
    end
    return lo;
  endfunction

  function automatic longint point_distance(longint ex, longint ey);
    return rounded_root(0, ex * ex + ey * ey, 1);
  endfunction

  function automatic longint edge_distance(longint ax, longint ay, longint bx, longint by);
    longint dx, dy, ex, ey, len2, dot, cr;
    logic [127:0] sq;
    dx = bx - ax;
    dy = by - ay;
    ex = com_xq - ax;
    ey = com_yq - ay;
    len2 = dx * dx + dy * dy;
    if (len2 == 0) return point_distance(ex, ey);
    dot = ex * dx + ey * dy;
    if (dot <= 0) return point_distance(ex, ey);
    if (dot >= len2) return point_distance(com_xq - bx, com_yq - by);
    cr = ex * dy - ey * dx;
    if (cr < 0) cr = -cr;
    sq = 128'(cr) * 128'(cr);
    return rounded_root(sq[127:64], sq[63:0], len2);
  endfunction

  function automatic longint mean_rounded(longint sum, longint n);
    longint mag, q;
    mag = sum < 0 ? -sum : sum;
    q = (2 * mag + n) / (2 * n);
    return sum < 0 ? -q : q;
  endfunction

  function automatic spm_pkg::out_t polygon_margin();
    longint px[spm_pkg::NUM_FEET], py[spm_pkg::NUM_FEET];
    longint sx, sy, best, d;
    int n, j;
    spm_pkg::out_t r;
    sx = 0;
    sy = 0;
    n = 0;
    best = spm_pkg::MARGIN_MAX;
    r = '0;
    for (int i = 0; i < spm_pkg::NUM_FEET; i++) begin
      if (mask_q[i]) begin
        px[n] = feet_x[i];
        py[n] = feet_y[i];
        sx += px[n];
        sy += py[n];
        n++;
      end
    end
    if (n > 0) begin
      r.centroid_x = 16'(mean_rounded(sx, n));
      r.centroid_y = 16'(mean_rounded(sy, n));
      for (int i = 0; i < n; i++) begin
        j = (i + 1 == n) ? 0 : i + 1;
        d = edge_distance(px[i], py[i], px[j], py[j]);
        if (d < best) best = d;
      end
    end
    r.margin = 17'(best);
    r.support_count = 3'(n);
    r.margin_valid = n > 0;
    return r;
  endfunction

  function automatic void predict_transaction(spm_pkg::in_t t);
    bit fire;
    fire = 1'b1;
    case (t.op)
      spm_pkg::OP_FOOT: begin
        if (t.foot_index >= spm_pkg::NUM_FEET) return;
        feet_x[t.foot_index] = longint'(t.x);
        feet_y[t.foot_index] = longint'(t.y);
        if (!t.commit) return;
        got_positions = 1'b1;
      end
      spm_pkg::OP_MASK: begin
        mask_q = t.grounded_bits[spm_pkg::NUM_FEET-1:0];
        got_mask = 1'b1;
      end
      spm_pkg::OP_COM: begin
        com_xq = longint'(t.x);
        com_yq = longint'(t.y);
      end
      default: fire = 1'b0;
    endcase
    if (fire && got_positions && got_mask)
      expected_results.insert(expected_results.size(), polygon_margin());
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic random_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  task automatic send_item(spm_pkg::in_t t);
    random_gap();
    in_ch.data  <= t;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_transaction(t);
    @(negedge clk_i);
  endtask

  function automatic spm_pkg::in_t make_item(logic [1:0] op, logic [2:0] idx, logic [15:0] x,
                                             logic [15:0] y, logic [5:0] bits, logic c);
    spm_pkg::in_t t;
    t.op = op;
    t.foot_index = idx;
    t.x = x;
    t.y = y;
    t.grounded_bits = bits;
    t.commit = c;
    return t;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_item(make_item(spm_pkg::OP_COM, 3'd0, 16'd5, 16'd5, 6'd0, 1'b0));
    send_item(make_item(spm_pkg::OP_MASK, 3'd0, 16'd0, 16'd0, 6'h3f, 1'b0));
    send_item(make_item(spm_pkg::OP_FOOT, 3'd6, 16'd1, 16'd1, 6'd0, 1'b1));
    send_item(make_item(spm_pkg::OP_FOOT, 3'd7, 16'd1, 16'd1, 6'd0, 1'b1));
    send_item(make_item(spm_pkg::OP_UNUSED, 3'd0, 16'd1, 16'd1, 6'h3f, 1'b1));
    for (int i = 0; i < spm_pkg::NUM_FEET; i++)
      send_item(make_item(spm_pkg::OP_FOOT, 3'(i), i[0] ? 16'h7fff : 16'h8000,
                          i[1] ? 16'h8000 : 16'h7fff, 6'd0, i == spm_pkg::NUM_FEET - 1));
    send_item(make_item(spm_pkg::OP_MASK, 3'd0, 16'd0, 16'd0, 6'd0, 1'b0));
    send_item(make_item(spm_pkg::OP_MASK, 3'd0, 16'd0, 16'd0, 6'h04, 1'b0));
    send_item(make_item(spm_pkg::OP_MASK, 3'd0, 16'd0, 16'd0, 6'h03, 1'b0));
    send_item(make_item(spm_pkg::OP_COM, 3'd0, 16'h8000, 16'h7fff, 6'd0, 1'b0));
    send_item(make_item(spm_pkg::OP_MASK, 3'd0, 16'd0, 16'd0, 6'h3f, 1'b0));
    send_item(make_item(spm_pkg::OP_FOOT, 3'd2, 16'h7fff, 16'h8000, 6'd0, 1'b0));
    send_item(make_item(spm_pkg::OP_FOOT, 3'd1, 16'h8000, 16'h8000, 6'd0, 1'b1));
    send_item(make_item(spm_pkg::OP_COM, 3'd0, 16'h7fff, 16'h8000, 6'd0, 1'b0));
    send_item(make_item(spm_pkg::OP_COM, 3'd0, 16'h0000, 16'h0000, 6'd0, 1'b0));
  endtask

  task automatic test_random(int count);
    spm_pkg::in_t t;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 19);
      t.op = 2'($urandom);
      t.foot_index = 3'($urandom);
      t.grounded_bits = 6'($urandom);
      t.commit = 1'($urandom);
      t.x = rand_coord();
      t.y = rand_coord();
      if (kind < 8) begin
        t.op = spm_pkg::OP_FOOT;
        t.foot_index = 3'($urandom_range(0, spm_pkg::NUM_FEET - 1));
        t.commit = $urandom_range(0, 2) == 0;
      end else if (kind < 12) t.op = spm_pkg::OP_MASK;
      else if (kind < 18) t.op = spm_pkg::OP_COM;
      send_item(t);
    end
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transaction", 1, 0);
      end else begin
        spm_pkg::out_t e;
        e = expected_results.pop_front();
        if (out_ch.data.centroid_x != e.centroid_x)
          report_mismatch("centroid_x", out_ch.data.centroid_x, e.centroid_x);
        if (out_ch.data.centroid_y != e.centroid_y)
          report_mismatch("centroid_y", out_ch.data.centroid_y, e.centroid_y);
        if (out_ch.data.margin != e.margin)
          report_mismatch("margin", out_ch.data.margin, e.margin);
        if (out_ch.data.support_count != e.support_count)
          report_mismatch("support_count", out_ch.data.support_count, e.support_count);
        if (out_ch.data.margin_valid != e.margin_valid)
          report_mismatch("margin_valid", out_ch.data.margin_valid, e.margin_valid);
      end
    end
  end

  // output idling in random bursts
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_gap = $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    out_gap = 0;
    idle_on = 1'b1;
    foreach (feet_x[i]) begin
      feet_x[i] = 0;
      feet_y[i] = 0;
    end
    mask_q = '0;
    com_xq = 0;
    com_yq = 0;
    got_positions = 1'b0;
    got_mask = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(1100);
    idle_on = 1'b0;
    test_random(200);
    in_ch.valid <= 1'b0;
    drain();
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
